>>> src/rpca_pkg.sv
// Package for the ray pair closest approach pipeline: widths, codes and context types.
`timescale 1ns / 1ps
`default_nettype none

package rpca_pkg;

  // Channel and register widths
  localparam int IN_W    = 304;
  localparam int OUT_W   = 64;
  localparam int USER_W  = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 64;
  localparam int THR_W   = 33;

  // Field widths
  localparam int ORG_W   = 32;
  localparam int DIR_W   = 18;
  localparam int DOT_W   = 22;
  localparam int PROJ_W  = 37;
  localparam int NUM_W   = 56;

  // Long division: one quotient bit per stage
  localparam int DIV_STEPS   = 31;
  localparam int PIPE_STAGES = DIV_STEPS + 7;

  localparam logic [THR_W-1:0] THR_RESET = 33'd4295;

  // Register index decoded from paddr
  typedef enum logic [0:0] {
    REG_PARALLEL_THRESHOLD = 1'b0,
    REG_UNMAPPED           = 1'b1
  } reg_idx_e;

  // Per-item values carried alongside the divider
  typedef struct packed {
    logic                       par;
    logic                       neg;
    logic                       sat_a;
    logic signed [DIR_W-1:0]    dot;
    logic signed [PROJ_W-1:0]   pb;
  } ctx_t;

endpackage

`default_nettype wire

>>> src/ray_pair_closest_approach.sv
// Top level: fully pipelined closest approach of two rays with APB threshold register.
`timescale 1ns / 1ps
`default_nettype none

// Channel     Direction  Contents
// s_axis      in         two rays (origins Q16.16, unit directions Q2.16)
// m_axis      out        distance along each ray, found and saturated flags
// apb         in/out     parallel_threshold at byte address 0
//
// 39 register stages, from s1 through the divider to the output register. One pair per
// cycle while the output is not stalled.
// The restoring divider has 31 stages, one quotient bit per stage.
// Reset clears the valid bits, including the output valid, and sets the threshold to 4295.
// A stall at the output freezes every stage; s_axis_tready drops in the same cycle.

module ray_pair_closest_approach (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rpca_pkg::ADDR_W-1:0]   paddr,
  input  logic [rpca_pkg::DATA_W-1:0]   pwdata,
  output logic [rpca_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // from bit 0: origin_a_x/y/z (32 each), direction_a_x/y/z (18 each),
  // origin_b_x/y/z (32 each), direction_b_x/y/z (18 each), 4 zero bits
  input  logic [rpca_pkg::IN_W-1:0]     s_axis_tdata,
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // from bit 0: distance_along_a (32), distance_along_b (32)
  output logic [rpca_pkg::OUT_W-1:0]    m_axis_tdata,
  // from bit 0: found, saturated
  output logic [rpca_pkg::USER_W-1:0]   m_axis_tuser
);
  import rpca_pkg::*;

  localparam int DIV_STG = 5;   // pipeline index of the first divider stage

  // ---------------------------------------------------------------
  // Configuration register
  logic [THR_W-1:0] thr_q;
  reg_idx_e         reg_idx;

  assign reg_idx = reg_idx_e'(paddr[3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_PARALLEL_THRESHOLD)) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PARALLEL_THRESHOLD: prdata = {{(DATA_W-THR_W){1'b0}}, thr_q};
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Pipeline control: every stage advances together
  logic                   en;
  logic [PIPE_STAGES-1:0] stg_vld_q;
  logic                   out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      stg_vld_q <= {stg_vld_q[PIPE_STAGES-2:0], s_axis_tvalid};
      out_vld_q <= stg_vld_q[PIPE_STAGES-1];
    end
  end

  // ---------------------------------------------------------------
  // Input unpacking
  logic signed [ORG_W-1:0] oa [3];
  logic signed [ORG_W-1:0] ob [3];
  logic signed [DIR_W-1:0] da [3];
  logic signed [DIR_W-1:0] db [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      oa[k] = s_axis_tdata[ORG_W*k +: ORG_W];
      da[k] = s_axis_tdata[3*ORG_W + DIR_W*k +: DIR_W];
      ob[k] = s_axis_tdata[3*ORG_W + 3*DIR_W + ORG_W*k +: ORG_W];
      db[k] = s_axis_tdata[6*ORG_W + 3*DIR_W + DIR_W*k +: DIR_W];
    end
  end

  // ---------------------------------------------------------------
  // Stage registers
  logic signed [ORG_W:0]       w_q   [3];   // s1: origin difference
  logic signed [2*DIR_W-1:0]   pdd_q [3];   // s1: da*db
  logic signed [DIR_W-1:0]     da_q  [3];
  logic signed [DIR_W-1:0]     db_q  [3];
  logic signed [DOT_W-1:0]     dot2_q;       // s2
  logic signed [ORG_W+DIR_W:0] wa_q  [3];
  logic signed [ORG_W+DIR_W:0] wb_q  [3];
  logic signed [2*DOT_W-1:0]   dsq_q;        // s3
  logic signed [DOT_W-1:0]     dot3_q;
  logic signed [PROJ_W-1:0]    pa3_q, pb3_q;
  logic                        par4_q;       // s4
  logic [THR_W-1:0]            q4_q;
  logic signed [PROJ_W+DIR_W-1:0] pbd4_q;
  logic signed [PROJ_W-1:0]    pa4_q, pb4_q;
  logic signed [DIR_W-1:0]     dot4_q;
  logic [NUM_W-1:0]            mag5_q;       // s5
  logic [THR_W-1:0]            q5_q;
  ctx_t                        ctx5_q;

  // Divider stages: index 0 is loaded from s5, index DIV_STEPS holds the quotient
  logic [THR_W-1:0]     r_q   [DIV_STEPS+1];
  logic [THR_W-1:0]     qd_q  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS+1];
  logic [14:0]          lo_q  [DIV_STEPS+1];
  ctx_t                 ctx_q [DIV_STEPS+1];
  logic [THR_W-1:0]     r_d   [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_d [DIV_STEPS];

  logic signed [ORG_W-1:0]       ta7_q;     // s7
  logic signed [ORG_W+DIR_W-1:0] prod7_q;
  ctx_t                          ctx7_q;

  logic [OUT_W-1:0]  out_data_q;
  logic [USER_W-1:0] out_user_q;

  // ---------------------------------------------------------------
  // Combinational pieces between stages
  logic signed [2*DIR_W+1:0]   dsum;
  logic signed [ORG_W+DIR_W+2:0] sa, sb;
  logic signed [2*DOT_W-1:0]   denom;
  logic signed [NUM_W-1:0]     num;
  logic                        sat_a;
  logic [DIV_STEPS:0]          tmag;
  logic signed [ORG_W-1:0]     ta;
  logic signed [PROJ_W:0]      tb;
  logic                        tb_hi, tb_lo;

  always_comb begin
    dsum = 38'(pdd_q[0]) + 38'(pdd_q[1]) + 38'(pdd_q[2]);
    sa   = 53'(wa_q[0]) + 53'(wa_q[1]) + 53'(wa_q[2]);
    sb   = 53'(wb_q[0]) + 53'(wb_q[1]) + 53'(wb_q[2]);
    denom = $signed(44'h1_0000_0000) - dsq_q;
    num   = NUM_W'(pbd4_q) - $signed({(NUM_W-16)'(pa4_q), 16'h0000});
    sat_a = mag5_q >= {8'h00, q5_q, 15'h0000};
  end

  // One restoring division step per stage
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      logic [THR_W:0] rs;
      logic           ge;
      rs       = {r_q[k], lo_q[k][14]};
      ge       = rs >= {1'b0, qd_q[k]};
      r_d[k]   = ge ? THR_W'(rs - {1'b0, qd_q[k]}) : rs[THR_W-1:0];
      quo_d[k] = {quo_q[k][DIV_STEPS-2:0], ge};
    end
  end

  // Sign, saturation of distance a, then distance b with clamp
  always_comb begin
    tmag = {1'b0, quo_q[DIV_STEPS]};
    if (ctx_q[DIV_STEPS].sat_a) begin
      ta = ctx_q[DIV_STEPS].neg ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
    end else begin
      ta = ctx_q[DIV_STEPS].neg ? -$signed(tmag) : $signed(tmag);
    end
    tb    = (PROJ_W+1)'(ctx7_q.pb) +
            (PROJ_W+1)'($signed(prod7_q[ORG_W+DIR_W-1:16]));
    tb_hi = !tb[PROJ_W] && (tb[PROJ_W-1:ORG_W-1] != '0);
    tb_lo = tb[PROJ_W] && (tb[PROJ_W-1:ORG_W-1] != '1);
  end

  // ---------------------------------------------------------------
  // Datapath registers (no reset)
  always_ff @(posedge clk_i) begin
    if (en) begin
      // s1: differences and direction products
      for (int k = 0; k < 3; k++) begin
        w_q[k]   <= (ORG_W+1)'(oa[k]) - (ORG_W+1)'(ob[k]);
        pdd_q[k] <= da[k] * db[k];
        da_q[k]  <= da[k];
        db_q[k]  <= db[k];
      end
      // s2: dot product, projections of w
      dot2_q <= dsum[2*DIR_W+1:16];
      for (int k = 0; k < 3; k++) begin
        wa_q[k] <= w_q[k] * da_q[k];
        wb_q[k] <= w_q[k] * db_q[k];
      end
      // s3: dot squared, pa and pb
      dsq_q  <= dot2_q * dot2_q;
      dot3_q <= dot2_q;
      pa3_q  <= sa[ORG_W+DIR_W+2:16];
      pb3_q  <= sb[ORG_W+DIR_W+2:16];
      // s4: denominator, parallel test, pb*dot
      par4_q <= denom <= $signed({11'h000, thr_q});
      q4_q   <= denom[THR_W-1:0];
      pbd4_q <= pb3_q * $signed(dot3_q[DIR_W-1:0]);
      pa4_q  <= pa3_q;
      pb4_q  <= pb3_q;
      dot4_q <= dot3_q[DIR_W-1:0];
      // s5: numerator magnitude
      mag5_q       <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      q5_q         <= q4_q;
      ctx5_q.par   <= par4_q;
      ctx5_q.neg   <= num[NUM_W-1];
      ctx5_q.sat_a <= 1'b0;
      ctx5_q.dot   <= dot4_q;
      ctx5_q.pb    <= pb4_q;
      // s6: divider entry and overflow check
      r_q[0]   <= mag5_q[47:15];
      lo_q[0]  <= mag5_q[14:0];
      quo_q[0] <= '0;
      qd_q[0]  <= q5_q;
      ctx_q[0] <= '{par: ctx5_q.par, neg: ctx5_q.neg, sat_a: sat_a,
                    dot: ctx5_q.dot, pb: ctx5_q.pb};
      // divider stages
      for (int k = 0; k < DIV_STEPS; k++) begin
        r_q[k+1]   <= r_d[k];
        quo_q[k+1] <= quo_d[k];
        lo_q[k+1]  <= {lo_q[k][13:0], 1'b0};
        qd_q[k+1]  <= qd_q[k];
        ctx_q[k+1] <= ctx_q[k];
      end
      // s7: distance a and its product with dot
      ta7_q   <= ta;
      prod7_q <= ta * ctx_q[DIV_STEPS].dot;
      ctx7_q  <= ctx_q[DIV_STEPS];
      // output register
      if (ctx7_q.par) begin
        out_data_q <= '0;
        out_user_q <= '0;
      end else begin
        out_data_q[ORG_W-1:0] <= ta7_q;
        priority if (tb_hi) begin
          out_data_q[OUT_W-1:ORG_W] <= 32'h7FFF_FFFF;
        end else if (tb_lo) begin
          out_data_q[OUT_W-1:ORG_W] <= 32'h8000_0000;
        end else begin
          out_data_q[OUT_W-1:ORG_W] <= tb[ORG_W-1:0];
        end
        out_user_q <= {ctx7_q.sat_a || tb_hi || tb_lo, 1'b1};
      end
    end
  end

  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_user_q;

  // ---------------------------------------------------------------
  // Assertions
  a_parallel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
    else $error("parallel result carries nonzero data or flag");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(stg_vld_q))
    else $error("pipeline moved during output stall");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_vld_q[DIV_STG+DIV_STEPS] && !ctx_q[DIV_STEPS].par && !ctx_q[DIV_STEPS].sat_a)
      |-> (r_q[DIV_STEPS] < qd_q[DIV_STEPS]))
    else $error("divider remainder not below divisor");

  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> stg_vld_q[0])
    else $error("accepted transaction lost at first stage");

endmodule

`default_nettype wire
